[sv/mvpd_pkg.sv]
// Shared constants and field widths of the majority-vote port debounce.
package mvpd_pkg;

  localparam int unsigned HistDepth   = 3;
  localparam int unsigned PortSlots   = 16;

  localparam int unsigned SlotW       = 4;
  localparam int unsigned SampleW     = 8;
  localparam int unsigned ChipCountW  = 4;
  localparam int unsigned StreamDataW = 16;

endpackage

[sv/majority_vote_port_debounce.sv]
// Majority-vote debounce over a per-port sample history held in one memory.
// A sample passes stage 1 (row read), then the output register (vote); one sample per cycle
// unless the output is held. The history memory is read in the accept cycle and written back
// as stage 1 moves on, with a write-to-read bypass for the same port.
// Reset: history rows read as all ones until first written (one flag per row),
// the shared history slot and the active chip count return to zero.
module majority_vote_port_debounce #(
  parameter int unsigned HISTORY_DEPTH = mvpd_pkg::HistDepth,
  parameter int unsigned PORT_SLOTS    = mvpd_pkg::PortSlots
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: active_chip_count
  input  logic                               cfg_we_i,
  input  logic [mvpd_pkg::ChipCountW-1:0]    cfg_wdata_i,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [3:0] port_slot, [11:4] raw_sample, [15:12] zero
  input  logic [mvpd_pkg::StreamDataW-1:0]   s_axis_tdata,
  input  logic                               s_axis_tlast,   // scan_end
  // voted stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [3:0] result_slot, [11:4] voted_byte, [15:12] zero
  output logic [mvpd_pkg::StreamDataW-1:0]   m_axis_tdata,
  output logic                               m_axis_tuser    // slot_valid
);
  import mvpd_pkg::*;

  localparam int unsigned AddrW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam int unsigned PosW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned RowW  = HISTORY_DEPTH * SampleW;
  localparam int unsigned CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SlotCmpW = (AddrW + 1 > SlotW + 1) ? AddrW + 1 : SlotW + 1;
  localparam logic [PosW-1:0]     LastPos = PosW'(HISTORY_DEPTH - 1);
  localparam logic [CntW-1:0]     HalfCnt = CntW'(HISTORY_DEPTH / 2);
  localparam logic [SlotCmpW-1:0] SlotLim = SlotCmpW'(PORT_SLOTS);

  // Configuration register: the user must write it only while the stream is idle; the block does not enforce this.
  logic [ChipCountW-1:0] chip_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_cnt_q <= '0;
    end else if (cfg_we_i) begin
      chip_cnt_q <= cfg_wdata_i;
    end
  end

  // Unpack the incoming transfer.
  logic [SlotW-1:0]   in_slot;
  logic [SampleW-1:0] in_sample;
  logic               in_fire;
  logic               in_ok;

  assign in_slot   = s_axis_tdata[SlotW-1:0];
  assign in_sample = s_axis_tdata[SlotW +: SampleW];
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // A slot is stored only below twice the chip count and inside the memory.
  assign in_ok = ({1'b0, in_slot} < {chip_cnt_q, 1'b0}) &&
                 (SlotCmpW'(in_slot) < SlotLim);

  // Shared history slot: advance on the last sample of a scan, wrap at the depth.
  logic [PosW-1:0] hist_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_pos_q <= '0;
    end else if (in_fire && s_axis_tlast) begin
      hist_pos_q <= (hist_pos_q == LastPos) ? '0 : hist_pos_q + PosW'(1);
    end
  end

  // Stage 1: the sample waits here while its history row is read.
  logic               s1_vld_q;
  logic [SlotW-1:0]   s1_slot_q;
  logic [SampleW-1:0] s1_sample_q;
  logic [PosW-1:0]    s1_pos_q;
  logic               s1_ok_q;
  logic               s1_adv;

  // Output register.
  logic               out_vld_q;
  logic [SlotW-1:0]   out_slot_q;
  logic [SampleW-1:0] out_voted_q;
  logic               out_ok_q;

  // Stage 1 moves on when the output register is empty or being drained;
  // a new sample enters whenever stage 1 is empty or moving on.
  assign s1_adv        = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !s1_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_slot_q   <= in_slot;
      s1_sample_q <= in_sample;
      s1_pos_q    <= hist_pos_q;
      s1_ok_q     <= in_ok;
    end
  end

  // History memory: one row per port, one byte per history entry.
  logic [RowW-1:0]       hist_mem [PORT_SLOTS];
  logic [PORT_SLOTS-1:0] row_vld_q;
  logic [RowW-1:0]       rd_row_q;
  logic                  rd_row_vld_q;

  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;
  logic             rd_en;
  logic             wr_en;
  logic [RowW-1:0]  wr_row;
  logic             bypass;

  assign rd_addr = AddrW'(in_slot);
  assign wr_addr = AddrW'(s1_slot_q);
  assign rd_en   = in_fire && in_ok;
  assign wr_en   = s1_vld_q && s1_adv && s1_ok_q;
  // Same port written back in the cycle it is read: take the new row.
  assign bypass  = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_row_q <= bypass ? wr_row : hist_mem[rd_addr];
    end
  end

  // Row flags: an unwritten row reads as all ones.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q    <= '0;
      rd_row_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_row_vld_q <= bypass || row_vld_q[rd_addr];
      end
    end
  end

  // Modify: drop the sample into the current history entry of its row.
  logic [RowW-1:0]    base_row;
  logic [SampleW-1:0] voted;

  assign base_row = rd_row_vld_q ? rd_row_q : '1;

  always_comb begin
    for (int unsigned e = 0; e < HISTORY_DEPTH; e++) begin
      if (s1_pos_q == PosW'(e)) begin
        wr_row[e*SampleW +: SampleW] = s1_sample_q;
      end else begin
        wr_row[e*SampleW +: SampleW] = base_row[e*SampleW +: SampleW];
      end
    end
  end

  // Vote: a bit is set when more than half of its history entries are ones.
  always_comb begin
    logic [CntW-1:0] ones;
    for (int unsigned b = 0; b < SampleW; b++) begin
      ones = '0;
      for (int unsigned e = 0; e < HISTORY_DEPTH; e++) begin
        ones = ones + CntW'(wr_row[e*SampleW + b]);
      end
      voted[b] = ones > HalfCnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_vld_q) begin
      out_slot_q  <= s1_slot_q;
      out_voted_q <= s1_ok_q ? voted : '0;
      out_ok_q    <= s1_ok_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(StreamDataW - SlotW - SampleW){1'b0}}, out_voted_q, out_slot_q};
  assign m_axis_tuser  = out_ok_q;

  // A held stage 1 must block new samples.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_adv) |-> !s_axis_tready)
    else $error("sample accepted while stage 1 is held");

  // A rejected slot carries a zero vote.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (out_voted_q == '0))
    else $error("invalid slot with nonzero vote");

  // The shared history slot stays inside the history depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_pos_q <= LastPos)
    else $error("history slot out of range");

  // Write-back only ever touches an active slot, below twice the chip count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ({1'b0, s1_slot_q} < {chip_cnt_q, 1'b0}))
    else $error("write-back to an inactive port");

endmodule

[verif/majority_vote_port_debounce_test.sv]
// Self-checking stream testbench for the majority-vote port debounce block.
`timescale 1ns / 1ps

module majority_vote_port_debounce_test;
  import mvpd_pkg::*;

  // Generous bound: about 1800 samples with random gaps, plus the long hold-off.
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned SettleCycles = 4;   // two-stage pipeline plus margin
  localparam int unsigned LongHold     = 300;

  // One voted result as the block reports it.
  typedef struct packed {
    logic [SlotW-1:0]   slot;
    logic [SampleW-1:0] voted;
    logic               valid;
  } vote_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [ChipCountW-1:0]  cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [3:0] port_slot, [11:4] raw_sample, [15:12] zero
  logic [StreamDataW-1:0] s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;   // scan_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [3:0] result_slot, [11:4] voted_byte, [15:12] zero
  logic [StreamDataW-1:0] m_axis_tdata;
  logic                   m_axis_tuser;           // slot_valid

  // Predictor state: per-port sample history, shared write position, chip count.
  logic [SampleW-1:0]    port_history [PortSlots][HistDepth];
  int unsigned           write_pos;
  logic [ChipCountW-1:0] chip_count;

  vote_t       vote_q[$];          // expected voted results, oldest first
  int unsigned samples_sent;
  int unsigned votes_seen;
  int unsigned valid_votes_seen;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned sink_wait;          // cycles the receiver still holds tready low
  int unsigned stall_request;      // long hold-off asked for by a test
  bit          src_gaps_on;
  bit          sink_gaps_on;

  majority_vote_port_debounce dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bring the predictor to the post-reset state: open inputs read as ones.
  function automatic void clear_history();
    for (int p = 0; p < PortSlots; p++) begin
      for (int w = 0; w < HistDepth; w++) begin
        port_history[p][w] = '1;
      end
    end
    write_pos  = 0;
    chip_count = '0;
  endfunction

  // Store the sample if its slot is active, vote each bit over the port's
  // history, then advance the shared write position on a scan end.
  function automatic vote_t predict_vote(logic [SlotW-1:0] slot,
                                         logic [SampleW-1:0] sample,
                                         logic scan_end);
    vote_t       res;
    int unsigned ones;
    res.slot  = slot;
    res.voted = '0;
    res.valid = (int'(slot) < 2 * int'(chip_count)) && (int'(slot) < PortSlots);
    if (res.valid) begin
      port_history[slot][write_pos] = sample;
      for (int b = 0; b < SampleW; b++) begin
        ones = 0;
        for (int w = 0; w < HistDepth; w++) begin
          ones += port_history[slot][w][b];
        end
        res.voted[b] = (ones > HistDepth / 2);
      end
    end
    // the write position moves even when the slot itself was rejected
    if (scan_end) begin
      write_pos = (write_pos + 1 >= HistDepth) ? 0 : write_pos + 1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer observers and checker
  // ---------------------------------------------------------------------------

  // Mirror every register write and every accepted sample into the predictor.
  // Values read here are the ones that were present before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        chip_count = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        vote_q.push_back(predict_vote(s_axis_tdata[SlotW-1:0],
                                      s_axis_tdata[SlotW +: SampleW],
                                      s_axis_tlast));
        samples_sent++;
      end
    end
  end

  function automatic void flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endfunction

  // Compare each result transfer with the oldest expected vote.
  always @(posedge clk_i) begin : check_votes
    vote_t want;
    vote_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.slot  = m_axis_tdata[SlotW-1:0];
      got.voted = m_axis_tdata[SlotW +: SampleW];
      got.valid = m_axis_tuser;
      votes_seen++;
      valid_votes_seen += got.valid;
      if (vote_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result slot %0d byte %02h valid %0b",
                                got.slot, got.voted, got.valid));
      end else begin
        want = vote_q.pop_front();
        if (got.slot !== want.slot) begin
          flag_mismatch($sformatf("result_slot expected %0d got %0d", want.slot, got.slot));
        end
        if (got.voted !== want.voted) begin
          flag_mismatch($sformatf("voted_byte of slot %0d expected %02h got %02h",
                                  want.slot, want.voted, got.voted));
        end
        if (got.valid !== want.valid) begin
          flag_mismatch($sformatf("slot_valid of slot %0d expected %0b got %0b",
                                  want.slot, want.valid, got.valid));
        end
      end
    end
  end

  // Receiver: after each transfer draw a random hold-off when gaps are on. A long
  // hold-off requested by a test takes precedence and is counted here.
  always @(posedge clk_i) begin : drive_sink
    int unsigned gap;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_request != 0) begin
      sink_wait      = stall_request - 1;
      stall_request  = 0;
      m_axis_tready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait--;
      m_axis_tready <= 1'b0;
    end else if (!m_axis_tready) begin
      m_axis_tready <= 1'b1;
    end else if (m_axis_tvalid) begin
      gap = sink_gaps_on ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        sink_wait      = gap - 1;
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d votes still expected", cycle_count,
               vote_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks (all start and end right after a rising edge)
  // ---------------------------------------------------------------------------

  // Offer one sample after a random gap and return at the edge of its transfer.
  // tvalid stays high on return so back-to-back samples need no extra assignment.
  task automatic send_sample(input logic [SlotW-1:0] slot,
                             input logic [SampleW-1:0] sample,
                             input logic scan_end);
    int unsigned gap;
    gap = src_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(StreamDataW - SlotW - SampleW){1'b0}}, sample, slot};
    s_axis_tlast  <= scan_end;
    // sample tready mid-cycle, the transfer happens at the following edge
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // Drop tvalid and hold until every expected vote has come back, then let
  // the pipeline settle so a register write finds the block idle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (vote_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_chip_count(input logic [ChipCountW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset no chip is active: every slot is rejected, yet a scan
  // end on a rejected slot still moves the write position.
  task automatic test_reset_state();
    send_sample(4'd0, 8'h00, 1'b0);
    send_sample(4'd15, 8'hFF, 1'b1);
    send_sample(4'd1, 8'hA5, 1'b1);
    send_sample(4'd0, 8'h5A, 1'b0);
    wait_drained();
  endtask

  // All eight chips active: history starts at all ones, votes follow the
  // majority once two of the three stored samples agree.
  task automatic test_full_chip_count();
    write_chip_count(4'd8);
    send_sample(4'd0, 8'h00, 1'b1);   // one zero against two ones
    send_sample(4'd0, 8'h00, 1'b1);   // majority flips to zero
    send_sample(4'd0, 8'h00, 1'b1);
    send_sample(4'd15, 8'hFF, 1'b0);
    send_sample(4'd15, 8'h00, 1'b0);  // same position overwritten
    send_sample(4'd7, 8'hAA, 1'b1);
    send_sample(4'd7, 8'h55, 1'b1);
    send_sample(4'd7, 8'hAA, 1'b1);
    send_sample(4'd1, 8'h80, 1'b1);
    send_sample(4'd1, 8'h01, 1'b1);
    send_sample(4'd1, 8'h81, 1'b0);
    wait_drained();
  endtask

  // Chip count above the nominal range, then the smallest non-zero count.
  task automatic test_chip_count_extremes();
    write_chip_count(4'd15);
    send_sample(4'd15, 8'h00, 1'b1);
    send_sample(4'd14, 8'hFF, 1'b0);
    wait_drained();
    write_chip_count(4'd1);
    send_sample(4'd1, 8'h5A, 1'b0);
    send_sample(4'd2, 8'hC3, 1'b1);   // just past the last active slot
    send_sample(4'd15, 8'h3C, 1'b0);
    wait_drained();
  endtask

  // Mostly complete scans over the active slots with slowly changing levels
  // and single-bit glitches; the rest is random noise and scans cut short.
  task automatic run_scans(input logic [ChipCountW-1:0] chips, input int unsigned n_items);
    logic [SampleW-1:0] level [PortSlots];
    logic [SampleW-1:0] glitch;
    int unsigned        sent;
    int unsigned        n_slots;
    int unsigned        last_slot;
    sent    = 0;
    n_slots = (2 * chips > PortSlots) ? PortSlots : 2 * chips;
    for (int p = 0; p < PortSlots; p++) begin
      level[p] = SampleW'($urandom);
    end
    write_chip_count(chips);
    while (sent < n_items) begin
      if (n_slots != 0 && $urandom_range(0, 9) < 8) begin
        last_slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_slots - 1)
                                                : n_slots - 1;
        for (int unsigned s = 0; s <= last_slot; s++) begin
          if ($urandom_range(0, 15) == 0) begin
            level[s] = SampleW'($urandom);
          end
          glitch = ($urandom_range(0, 3) == 0) ? SampleW'(1) << $urandom_range(0, 7) : '0;
          send_sample(SlotW'(s), level[s] ^ glitch, s == last_slot);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_sample(SlotW'($urandom), SampleW'($urandom), 1'($urandom));
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  // Random phases over several chip counts, extremes included; one phase
  // runs with no idling on either side.
  task automatic test_random();
    run_scans(4'd8, 220);
    run_scans(4'd15, 220);
    run_scans(4'd0, 60);
    run_scans(4'd1, 200);
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    run_scans(4'd8, 220);
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    run_scans(ChipCountW'($urandom_range(2, 7)), 220);
    run_scans(4'd3, 200);
    run_scans(ChipCountW'($urandom_range(9, 15)), 200);
    run_scans(ChipCountW'($urandom), 200);
  endtask

  // Hold the receiver off for a long stretch while samples keep coming, so
  // the block fills up and stalls its input; then drain before going on.
  task automatic test_backpressure();
    write_chip_count(4'd8);
    @(negedge clk_i);
    stall_request = LongHold;
    @(posedge clk_i);
    for (int i = 0; i < 60; i++) begin
      send_sample(SlotW'($urandom), SampleW'($urandom), 1'($urandom_range(0, 3) == 0));
    end
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      send_sample(SlotW'(i % PortSlots), SampleW'($urandom), 1'(i % PortSlots == 15));
    end
    wait_drained();
  endtask

  initial begin
    clear_history();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_full_chip_count();
    test_chip_count_extremes();
    test_random();
    test_backpressure();

    wait_drained();
    $display("Ran %0d samples, %0d votes checked (%0d on active slots).",
             samples_sent, votes_seen, valid_votes_seen);
    $display("Chip counts 0, 1, 8, 15 and random, scan-end wrap, long receiver stall.");
    if (mismatch_count == 0 && vote_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d votes missing", mismatch_count, vote_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
